@@ rtl/qfr_pkg.sv @@
// shared constants, status codes and pipeline control type for the quadratic factor reflector
package qfr_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int WORD_BITS_DEF = 32;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_SAT  = 2'd1;
    localparam logic [1:0] ST_DIVZ = 2'd2;

    // per-cell pipeline control
    typedef struct packed {
        logic en;
        logic vld;
    } qfr_ctl_t;

endpackage

@@ rtl/quadratic_factor_unit_circle_reflect_top.sv @@
// top level of the quadratic factor unit-circle reflector
// Takes a factor x^2 - r*x + t (signed fixed point, FRAC_BITS fraction bits in a
// WORD_BITS word) and returns the sum and product of a factor whose roots lie in
// the closed unit circle, with status ok, saturated, or divide by zero. One factor
// is accepted every clock cycle while the result side keeps up; the whole pipeline
// moves as one, so a stall on m_ready holds every stage. The stages are the input
// and discriminant registers, a row of RW square-root cells (about WORD_BITS+1),
// the operand register, a row of NW divider cells (about WORD_BITS+FRAC_BITS+2),
// then the last stage and the output register; at the defaults RW is 33 and NW is 50.
module quadratic_factor_unit_circle_reflect_top import qfr_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic signed [WORD_BITS-1:0] s_lin_coef,
    input  logic signed [WORD_BITS-1:0] s_const_coef,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic signed [WORD_BITS-1:0] m_sum_out,
    output logic signed [WORD_BITS-1:0] m_prod_out,
    output logic [1:0]                  m_status
);

    localparam int W    = WORD_BITS;
    localparam int F    = FRAC_BITS;
    localparam int PW   = 2 * W;                  // r squared
    localparam int T4W  = W + F + 2;              // t scaled by 4
    localparam int DW   = ((PW > T4W) ? PW : T4W) + 1;  // discriminant
    localparam int RW   = (DW + 1) / 2;           // square root bits, one cell each
    localparam int XW   = RW + 2;                 // signed first root
    localparam int AW   = RW + 1;                 // root magnitude, also divisor width
    localparam int NW   = ((AW + F) > (2 * F + 3)) ? (AW + F) : (2 * F + 3);
    localparam int MW   = F + 2;                  // reflected root magnitudes
    localparam int SW2  = MW + 2;                 // signed root sum
    localparam int SQSW = 1 + 2 * W;              // payload through the root row
    localparam int DVSW = 6 + AW;                 // payload through the divider row

    localparam logic [NW-1:0] SMAX_N = {{(NW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic [W-1:0]  SMAX_W = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0]  SMIN_W = {1'b1, {(W-1){1'b0}}};

    // clamp a sign and magnitude to the signed word, flag in the top bit
    function automatic logic [W:0] sat_clamp(input logic neg, input logic [NW-1:0] mag);
        logic [W:0] res;
        if (mag <= SMAX_N) begin
            res = {1'b0, (neg ? (~mag[W-1:0] + 1'b1) : mag[W-1:0])};
        end else if (neg && (mag == SMAX_N + 1'b1)) begin
            res = {1'b0, SMIN_W};
        end else begin
            res = {1'b1, (neg ? SMIN_W : SMAX_W)};
        end
        return res;
    endfunction

    // one enable for every stage: move when the output register is free or drains
    logic adv;
    assign adv     = !m_valid || m_ready;
    assign s_ready = adv;

    // stage 1: magnitudes and r squared
    logic [W-1:0]        ar_in, at_in;
    logic                v1_reg;
    logic signed [W-1:0] r1_reg, t1_reg;
    logic [PW-1:0]       rsq1_reg;

    assign ar_in = s_lin_coef[W-1]   ? (~s_lin_coef + 1'b1)   : s_lin_coef;
    assign at_in = s_const_coef[W-1] ? (~s_const_coef + 1'b1) : s_const_coef;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            r1_reg   <= s_lin_coef;
            t1_reg   <= s_const_coef;
            rsq1_reg <= ar_in * ar_in;
        end
    end

    // stage 2: discriminant and complex-pair test
    logic [W-1:0]        at1;
    logic [DW-1:0]       t4_ext, rsq_ext;
    logic                tpos1;
    logic                v2_reg, cplx2_reg;
    logic signed [W-1:0] r2_reg, t2_reg;
    logic [DW-1:0]       disc2_reg;

    assign at1     = t1_reg[W-1] ? (~t1_reg + 1'b1) : t1_reg;
    assign t4_ext  = DW'({at1, {(F+2){1'b0}}});
    assign rsq_ext = DW'(rsq1_reg);
    assign tpos1   = !t1_reg[W-1] && (t1_reg != '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (adv) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            r2_reg    <= r1_reg;
            t2_reg    <= t1_reg;
            cplx2_reg <= tpos1 && (rsq_ext < t4_ext);
            disc2_reg <= tpos1 ? (rsq_ext - t4_ext) : (rsq_ext + t4_ext);
        end
    end

    // square root row, two radicand bits per cell
    logic            sq_vld  [RW+1];
    logic [RW+3:0]   sq_rem  [RW+1];
    logic [RW-1:0]   sq_root [RW+1];
    logic [2*RW-1:0] sq_rad  [RW+1];
    logic [SQSW-1:0] sq_side [RW+1];

    assign sq_vld[0]  = v2_reg;
    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;
    assign sq_rad[0]  = (2*RW)'(disc2_reg);
    assign sq_side[0] = {cplx2_reg, r2_reg, t2_reg};

    for (genvar i = 0; i < RW; i++) begin : g_sqrt
        qfr_sqrt_cell #(.RW(RW), .SW(SQSW)) u_cell (
            .aclk   (aclk),
            .aresetn(aresetn),
            .ctl_i  ('{en: adv, vld: sq_vld[i]}),
            .rem_i  (sq_rem[i]),
            .root_i (sq_root[i]),
            .rad_i  (sq_rad[i]),
            .side_i (sq_side[i]),
            .vld_o  (sq_vld[i+1]),
            .rem_o  (sq_rem[i+1]),
            .root_o (sq_root[i+1]),
            .rad_o  (sq_rad[i+1]),
            .side_o (sq_side[i+1])
        );
    end

    // stage 3: first root, reflection tests and divider operands
    logic                cplx_s;
    logic signed [W-1:0] r_s, t_s;
    logic [W-1:0]        ar_s, at_s;
    logic signed [XW-1:0] x1;
    logic [AW-1:0]       a1;
    logic                n1, c2;
    logic [NW-1:0]       num_a, num_b;
    logic [AW-1:0]       dvs_a, dvs_b;
    logic                v3_reg;
    logic [NW-1:0]       num_a3_reg, num_b3_reg;
    logic [AW-1:0]       dvs_a3_reg, dvs_b3_reg;
    logic [DVSW-1:0]     side3_reg;

    assign {cplx_s, r_s, t_s} = sq_side[RW];

    always_comb begin
        ar_s = r_s[W-1] ? (~r_s + 1'b1) : r_s;
        at_s = t_s[W-1] ? (~t_s + 1'b1) : t_s;
        x1   = r_s[W-1] ? (XW'(r_s) - $signed({2'b00, sq_root[RW]}))
                        : (XW'(r_s) + $signed({2'b00, sq_root[RW]}));
        a1   = x1[XW-1] ? AW'(-x1) : AW'(x1);
        n1   = x1[XW-1];
        c2   = ({1'b0, AW'(at_s), 1'b0} > {2'b00, a1});
        if (cplx_s) begin
            num_a = NW'(ar_s) << F;
            dvs_a = AW'(at_s);
            num_b = NW'(1'b1) << (2 * F);
            dvs_b = AW'(at_s);
        end else begin
            num_a = NW'(1'b1) << (2 * F + 2);
            dvs_a = a1;
            num_b = c2 ? (NW'(a1) << F) : (NW'(at_s) << (F + 2));
            dvs_b = c2 ? AW'(at_s) : a1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (adv) begin
            v3_reg <= sq_vld[RW];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            num_a3_reg <= num_a;
            num_b3_reg <= num_b;
            dvs_a3_reg <= dvs_a;
            dvs_b3_reg <= dvs_b;
            // complex, zero root, r negative, root signs, first root reflected, |x1|
            side3_reg  <= {cplx_s, (x1 == '0), r_s[W-1], n1, (n1 ^ t_s[W-1]),
                           (a1 > (AW'(1'b1) << (F + 1))), a1};
        end
    end

    // divider row, one quotient bit per cell on both lanes
    logic            dv_vld   [NW+1];
    logic [NW-1:0]   dv_acc_a [NW+1];
    logic [AW-1:0]   dv_rem_a [NW+1];
    logic [AW-1:0]   dv_dvs_a [NW+1];
    logic [NW-1:0]   dv_acc_b [NW+1];
    logic [AW-1:0]   dv_rem_b [NW+1];
    logic [AW-1:0]   dv_dvs_b [NW+1];
    logic [DVSW-1:0] dv_side  [NW+1];

    assign dv_vld[0]   = v3_reg;
    assign dv_acc_a[0] = num_a3_reg;
    assign dv_rem_a[0] = '0;
    assign dv_dvs_a[0] = dvs_a3_reg;
    assign dv_acc_b[0] = num_b3_reg;
    assign dv_rem_b[0] = '0;
    assign dv_dvs_b[0] = dvs_b3_reg;
    assign dv_side[0]  = side3_reg;

    for (genvar j = 0; j < NW; j++) begin : g_div
        qfr_div_cell #(.NW(NW), .DVW(AW), .SW(DVSW)) u_cell (
            .aclk   (aclk),
            .aresetn(aresetn),
            .ctl_i  ('{en: adv, vld: dv_vld[j]}),
            .acc_a_i(dv_acc_a[j]),
            .rem_a_i(dv_rem_a[j]),
            .dvs_a_i(dv_dvs_a[j]),
            .acc_b_i(dv_acc_b[j]),
            .rem_b_i(dv_rem_b[j]),
            .dvs_b_i(dv_dvs_b[j]),
            .side_i (dv_side[j]),
            .vld_o  (dv_vld[j+1]),
            .acc_a_o(dv_acc_a[j+1]),
            .rem_a_o(dv_rem_a[j+1]),
            .dvs_a_o(dv_dvs_a[j+1]),
            .acc_b_o(dv_acc_b[j+1]),
            .rem_b_o(dv_rem_b[j+1]),
            .dvs_b_o(dv_dvs_b[j+1]),
            .side_o (dv_side[j+1])
        );
    end

    // stage 4: reflected roots, their sum and product
    logic                cplx_d, zero_d, rneg_d, n1_d, n2_d, refl_d;
    logic [AW-1:0]       a1_d;
    logic [MW-1:0]       m1, m2;
    logic signed [SW2-1:0] y1, y2;
    logic                v4_reg, cplx4_reg, zero4_reg, rneg4_reg, pneg4_reg;
    logic [NW-1:0]       qa4_reg, qb4_reg;
    logic signed [SW2-1:0] sum4_reg;
    logic [2*MW-1:0]     prod4_reg;

    assign {cplx_d, zero_d, rneg_d, n1_d, n2_d, refl_d, a1_d} = dv_side[NW];

    always_comb begin
        m1 = refl_d ? dv_acc_a[NW][MW-1:0] : a1_d[MW-1:0];
        m2 = dv_acc_b[NW][MW-1:0];
        y1 = n1_d ? -$signed({2'b00, m1}) : $signed({2'b00, m1});
        y2 = n2_d ? -$signed({2'b00, m2}) : $signed({2'b00, m2});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (adv) begin
            v4_reg <= dv_vld[NW];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            cplx4_reg <= cplx_d;
            zero4_reg <= zero_d;
            rneg4_reg <= rneg_d;
            pneg4_reg <= n1_d ^ n2_d;
            qa4_reg   <= dv_acc_a[NW];
            qb4_reg   <= dv_acc_b[NW];
            sum4_reg  <= y1 + y2;
            prod4_reg <= m1 * m2;
        end
    end

    // stage 5: halve the sum, scale the product, saturate into the output register
    logic [SW2-1:0]  sum_abs;
    logic [NW-1:0]   smag, pmag;
    logic [W:0]      cl_s, cl_p;
    logic signed [W-1:0] sum_next, prod_next;
    logic [1:0]      status_next;
    logic            m_valid_reg;
    logic signed [W-1:0] sum_reg, prod_reg;
    logic [1:0]      status_reg;

    always_comb begin
        sum_abs = sum4_reg[SW2-1] ? SW2'(-sum4_reg) : SW2'(sum4_reg);
        smag    = NW'(sum_abs >> 1);
        pmag    = NW'(prod4_reg[2*MW-1:F+2]);
        if (cplx4_reg) begin
            cl_s = sat_clamp(rneg4_reg, qa4_reg);
            cl_p = sat_clamp(1'b0, qb4_reg);
        end else begin
            cl_s = sat_clamp(sum4_reg[SW2-1], smag);
            cl_p = sat_clamp(pneg4_reg, pmag);
        end
        if (zero4_reg && !cplx4_reg) begin
            sum_next    = '0;
            prod_next   = '0;
            status_next = ST_DIVZ;
        end else begin
            sum_next    = cl_s[W-1:0];
            prod_next   = cl_p[W-1:0];
            status_next = (cl_s[W] || cl_p[W]) ? ST_SAT : ST_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            sum_reg    <= sum_next;
            prod_reg   <= prod_next;
            status_reg <= status_next;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_sum_out  = sum_reg;
    assign m_prod_out = prod_reg;
    assign m_status   = status_reg;

    // divide-by-zero results always carry zero coefficients
    a_divz_zero : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == ST_DIVZ) |-> (m_sum_out == '0) && (m_prod_out == '0))
        else $error("divide by zero result with nonzero coefficients");

    // a saturated status implies at least one coefficient sits at a rail
    a_sat_rail : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == ST_SAT) |->
            (m_sum_out == SMAX_W) || (m_sum_out == SMIN_W) ||
            (m_prod_out == SMAX_W) || (m_prod_out == SMIN_W))
        else $error("saturation flagged with no clamped coefficient");

    // a finished item in the last stage reaches the output register on the next move
    a_last_stage : assert property (@(posedge aclk) disable iff (!aresetn)
        v4_reg && adv |=> m_valid)
        else $error("result lost between last stage and output register");

    // a held result keeps the rest of the pipeline frozen
    a_freeze : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(v4_reg) && $stable(sum4_reg))
        else $error("pipeline moved while output stalled");

endmodule

@@ rtl/qfr_sqrt_cell.sv @@
// one restoring square-root step per cell, with side payload carried along
module qfr_sqrt_cell import qfr_pkg::*; #(
    parameter int RW = WORD_BITS_DEF + 1,
    parameter int SW = 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  qfr_ctl_t          ctl_i,
    input  logic [RW+3:0]     rem_i,
    input  logic [RW-1:0]     root_i,
    input  logic [2*RW-1:0]   rad_i,
    input  logic [SW-1:0]     side_i,
    output logic              vld_o,
    output logic [RW+3:0]     rem_o,
    output logic [RW-1:0]     root_o,
    output logic [2*RW-1:0]   rad_o,
    output logic [SW-1:0]     side_o
);

    logic [RW+3:0]   cur;
    logic [RW+3:0]   trial;
    logic            ge;
    logic [RW+3:0]   rem_next;
    logic [RW-1:0]   root_next;
    logic [2*RW-1:0] rad_next;
    logic            vld_reg;
    logic [RW+3:0]   rem_reg;
    logic [RW-1:0]   root_reg;
    logic [2*RW-1:0] rad_reg;
    logic [SW-1:0]   side_reg;

    always_comb begin
        cur       = {rem_i[RW+1:0], rad_i[2*RW-1 -: 2]};
        trial     = {2'b00, root_i, 2'b01};
        ge        = (cur >= trial);
        rem_next  = ge ? (cur - trial) : cur;
        root_next = {root_i[RW-2:0], ge};
        rad_next  = {rad_i[2*RW-3:0], 2'b00};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (ctl_i.en) begin
            vld_reg <= ctl_i.vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl_i.en) begin
            rem_reg  <= rem_next;
            root_reg <= root_next;
            rad_reg  <= rad_next;
            side_reg <= side_i;
        end
    end

    assign vld_o  = vld_reg;
    assign rem_o  = rem_reg;
    assign root_o = root_reg;
    assign rad_o  = rad_reg;
    assign side_o = side_reg;

endmodule

@@ rtl/qfr_div_cell.sv @@
// one restoring division step per cell on two lanes, with side payload carried along
module qfr_div_cell import qfr_pkg::*; #(
    parameter int NW  = 2 * WORD_BITS_DEF,
    parameter int DVW = WORD_BITS_DEF + 2,
    parameter int SW  = 1
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  qfr_ctl_t        ctl_i,
    input  logic [NW-1:0]   acc_a_i,
    input  logic [DVW-1:0]  rem_a_i,
    input  logic [DVW-1:0]  dvs_a_i,
    input  logic [NW-1:0]   acc_b_i,
    input  logic [DVW-1:0]  rem_b_i,
    input  logic [DVW-1:0]  dvs_b_i,
    input  logic [SW-1:0]   side_i,
    output logic            vld_o,
    output logic [NW-1:0]   acc_a_o,
    output logic [DVW-1:0]  rem_a_o,
    output logic [DVW-1:0]  dvs_a_o,
    output logic [NW-1:0]   acc_b_o,
    output logic [DVW-1:0]  rem_b_o,
    output logic [DVW-1:0]  dvs_b_o,
    output logic [SW-1:0]   side_o
);

    logic [DVW:0]   cur_a, cur_b, dif_a, dif_b;
    logic           ge_a, ge_b;
    logic           vld_reg;
    logic [NW-1:0]  acc_a_reg, acc_b_reg;
    logic [DVW-1:0] rem_a_reg, rem_b_reg, dvs_a_reg, dvs_b_reg;
    logic [SW-1:0]  side_reg;

    // shift next dividend bit into the partial remainder, quotient bit enters at the bottom
    always_comb begin
        cur_a = {rem_a_i, acc_a_i[NW-1]};
        cur_b = {rem_b_i, acc_b_i[NW-1]};
        ge_a  = (cur_a >= {1'b0, dvs_a_i});
        ge_b  = (cur_b >= {1'b0, dvs_b_i});
        dif_a = cur_a - {1'b0, dvs_a_i};
        dif_b = cur_b - {1'b0, dvs_b_i};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (ctl_i.en) begin
            vld_reg <= ctl_i.vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl_i.en) begin
            acc_a_reg <= {acc_a_i[NW-2:0], ge_a};
            acc_b_reg <= {acc_b_i[NW-2:0], ge_b};
            rem_a_reg <= ge_a ? dif_a[DVW-1:0] : cur_a[DVW-1:0];
            rem_b_reg <= ge_b ? dif_b[DVW-1:0] : cur_b[DVW-1:0];
            dvs_a_reg <= dvs_a_i;
            dvs_b_reg <= dvs_b_i;
            side_reg  <= side_i;
        end
    end

    assign vld_o   = vld_reg;
    assign acc_a_o = acc_a_reg;
    assign rem_a_o = rem_a_reg;
    assign dvs_a_o = dvs_a_reg;
    assign acc_b_o = acc_b_reg;
    assign rem_b_o = rem_b_reg;
    assign dvs_b_o = dvs_b_reg;
    assign side_o  = side_reg;

endmodule
